// ===== design/block_cyclic_task_index_map_macros.svh =====
// assertion macros shared by the index map rtl
`ifndef BLOCK_CYCLIC_TASK_INDEX_MAP_MACROS_SVH
`define BLOCK_CYCLIC_TASK_INDEX_MAP_MACROS_SVH

// condition implies consequence in the same cycle
`define BCTIM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("same-cycle check failed");

// condition implies consequence in the next cycle
`define BCTIM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/bctim_pkg.sv =====
// shared constants for the block cyclic task index map
package bctim_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int RANK_BITS_DEF  = 12;
    localparam int ORD_BITS       = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_ADDR_BITS  = 3;

    localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_START  = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_END    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_START = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SECOND_END   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WORKER_RANK  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WORKER_TOTAL = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CONTIGUOUS   = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_FAST   = 3'd7;

endpackage

// ===== design/block_cyclic_task_index_map.sv =====
// block cyclic task index map: local task ordinal to global index pair
//
// usage
//  - configuration: write registers over i_cfg_* (index, data); o_cfg_ready is always high.
//    after reset and after every write a setup sequencer rebuilds the range lengths,
//    task count and block base; s_axis_tready is low while it runs
//  - input: one 32-bit task ordinal per transfer on s_axis_*
//  - output: one result per input on m_axis_* with the indices, a valid flag and the
//    task count of this worker; indices read zero when the flag is low
//  - each result passes the input register, the divider stages and the output register
//  - throughput: one item per cycle while the output is not stalled and no setup runs; the
//    quotient and remainder come from a pipelined restoring divider, one quotient bit per stage, INDEX_BITS stages
//  - a stall on m_axis_tready freezes the whole pipeline; nothing is lost or repeated
//  - reset (synchronous, active low) restores the register defaults and empties the pipe
`include "block_cyclic_task_index_map_macros.svh"

module block_cyclic_task_index_map #(
    parameter int INDEX_BITS = bctim_pkg::INDEX_BITS_DEF,
    parameter int RANK_BITS  = bctim_pkg::RANK_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bctim_pkg::CFG_ADDR_BITS-1:0]  i_cfg_addr,
    input  logic [bctim_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // task_ordinal
    input  logic [bctim_pkg::ORD_BITS-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // first_index, second_index, valid_res, local_count, zero pad
    output logic [((4*INDEX_BITS+1+7)/8)*8-1:0]  m_axis_tdata
);

    localparam int W      = INDEX_BITS;
    localparam int CW     = 2 * INDEX_BITS;
    localparam int TW     = RANK_BITS + 1;
    localparam int OB     = bctim_pkg::ORD_BITS;
    localparam int OW     = (CW > OB) ? CW : OB;
    localparam int OUT_W  = ((4*INDEX_BITS+1+7)/8)*8;
    localparam int CNT_W  = $clog2(CW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CW - 1);

    typedef enum logic [1:0] {S_MUL, S_DIV, S_FIN, S_BASE} t_setup;
    // S_BASE returns to run state via r_busy
    t_setup r_state;
    logic   r_busy;

    logic [W-1:0]  r_fs, r_fe, r_ss, r_se;
    logic [RANK_BITS-1:0] r_rank;
    logic [TW-1:0] r_total;
    logic          r_contig, r_ffast;

    logic [CW-1:0]    r_num;
    logic [TW-1:0]    r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_dv;
    logic             r_nz;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_base;

    logic [W-1:0]  w_d1, w_d2;
    logic [TW-1:0] w_workers;
    logic [TW:0]   w_t;
    logic          w_ge;
    logic [CW+RANK_BITS-1:0] w_nprod;
    logic [TW-1:0] w_rank_x;
    logic          w_rank_ok, w_extra;
    logic [TW-1:0] w_min;

    assign o_cfg_ready = 1'b1;
    assign w_d1 = (r_fe > r_fs) ? r_fe - r_fs : '0;
    assign w_d2 = (r_se > r_ss) ? r_se - r_ss : '0;
    assign w_workers = (r_total == '0) ? TW'(1) : r_total;
    assign w_t  = {r_rem, r_num[CW-1]};
    assign w_ge = w_t >= {1'b0, w_workers};
    assign w_nprod = {{RANK_BITS{1'b0}}, r_num} * {{CW{1'b0}}, r_rank};
    assign w_rank_x  = {1'b0, r_rank};
    assign w_rank_ok = w_rank_x < w_workers;
    assign w_extra   = w_rank_x < r_rem;
    assign w_min     = (r_rem < w_rank_x) ? r_rem : w_rank_x;

    // config registers and setup sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs     <= '0;
            r_fe     <= '0;
            r_ss     <= '0;
            r_se     <= W'(1);
            r_rank   <= '0;
            r_total  <= TW'(1);
            r_contig <= 1'b1;
            r_ffast  <= 1'b1;
            r_state  <= S_MUL;
            r_busy   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                bctim_pkg::REG_FIRST_START:  r_fs     <= i_cfg_data[W-1:0];
                bctim_pkg::REG_FIRST_END:    r_fe     <= i_cfg_data[W-1:0];
                bctim_pkg::REG_SECOND_START: r_ss     <= i_cfg_data[W-1:0];
                bctim_pkg::REG_SECOND_END:   r_se     <= i_cfg_data[W-1:0];
                bctim_pkg::REG_WORKER_RANK:  r_rank   <= i_cfg_data[RANK_BITS-1:0];
                bctim_pkg::REG_WORKER_TOTAL: r_total  <= i_cfg_data[TW-1:0];
                bctim_pkg::REG_CONTIGUOUS:   r_contig <= i_cfg_data[0];
                bctim_pkg::REG_FIRST_FAST:   r_ffast  <= i_cfg_data[0];
                default: ;
            endcase
            r_state <= S_MUL;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            unique case (r_state)
                S_MUL: begin
                    r_num   <= {{W{1'b0}}, w_d1} * {{W{1'b0}}, w_d2};
                    r_dv    <= r_ffast ? w_d1 : w_d2;
                    r_nz    <= (w_d1 != '0) && (w_d2 != '0);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? TW'(w_t - {1'b0, w_workers}) : w_t[TW-1:0];
                    r_num <= {r_num[CW-2:0], w_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // quotient in r_num, remainder in r_rem
                    r_count <= (r_nz && w_rank_ok) ? r_num + CW'(w_extra) : '0;
                    r_base  <= w_nprod[CW-1:0];
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_base  <= r_base + CW'(w_min);
                    r_state <= S_MUL;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // item pipeline
    logic          w_en, w_acc;
    logic          r_v [0:W+1];
    logic          r_ok [0:W];
    logic [W-1:0]  r_rp [0:W];
    logic [W-1:0]  r_lp [0:W];
    logic [W-1:0]  r_fi, r_si;
    logic          r_ok_o;

    logic [OW-1:0]    w_ord_x;
    logic [CW-1:0]    w_id;
    logic [TW+OB-1:0] w_sprod;

    assign w_en  = !r_v[W+1] || m_axis_tready;
    assign s_axis_tready = w_en && !r_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_ord_x = OW'(s_axis_tdata);
    assign w_sprod = {{OB{1'b0}}, w_workers} * {{TW{1'b0}}, s_axis_tdata}
                   + (TW+OB)'(r_rank);
    assign w_id = r_contig ? CW'(w_ord_x + OW'(r_base)) : CW'(w_sprod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok[0] <= w_ord_x < OW'(r_count);
            r_rp[0] <= w_id[CW-1:W];
            r_lp[0] <= w_id[W-1:0];
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_div
        logic [W:0] w_st;
        logic       w_sge;
        assign w_st  = {r_rp[k-1], r_lp[k-1][W-1]};
        assign w_sge = w_st >= {1'b0, r_dv};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ok[k] <= r_ok[k-1];
                r_rp[k] <= w_sge ? W'(w_st - {1'b0, r_dv}) : w_st[W-1:0];
                if (W > 1) begin
                    r_lp[k] <= {r_lp[k-1][W-2:0], w_sge};
                end else begin
                    r_lp[k] <= W'(w_sge);
                end
            end
        end
    end

    // remainder in r_rp, quotient in r_lp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[W+1] <= 1'b0;
        end else if (w_en) begin
            r_v[W+1] <= r_v[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ok_o <= r_ok[W];
            if (!r_ok[W]) begin
                r_fi <= '0;
                r_si <= '0;
            end else if (r_ffast) begin
                r_fi <= r_fs + r_rp[W];
                r_si <= r_ss + r_lp[W];
            end else begin
                r_fi <= r_fs + r_lp[W];
                r_si <= r_ss + r_rp[W];
            end
        end
    end

    assign m_axis_tvalid = r_v[W+1];
    assign m_axis_tdata  = {{(OUT_W-4*W-1){1'b0}}, r_count, r_ok_o, r_si, r_fi};

    `BCTIM_ASSERT_SAME(a_no_take_in_setup, i_clk, i_rst_n, r_busy, !s_axis_tready)
    `BCTIM_ASSERT_NEXT(a_div_to_fin, i_clk, i_rst_n,
        r_busy && !i_cfg_valid && r_state == S_DIV && r_cnt == CNT_LAST, r_state == S_FIN)
    `BCTIM_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, r_v[W+1] && !r_ok_o,
        r_fi == '0 && r_si == '0)

endmodule

// ===== bench/tb_block_cyclic_task_index_map.sv =====
// testbench for the block cyclic task index map: predicted results against the stream output
`timescale 1ns / 100ps

class index_map_scoreboard;
    typedef struct packed {
        logic [15:0] first_index;
        logic [15:0] second_index;
        logic        valid_res;
        logic [31:0] local_count;
    } t_map_result;

    // register copies
    bit [15:0] first_start, first_end, second_start, second_end;
    bit [11:0] worker_rank;
    bit [12:0] worker_total;
    bit        contiguous_mode, first_fastest;
    t_map_result pending_maps[$];
    int errors;

    function new();
        first_start = 0; first_end = 0; second_start = 0; second_end = 1;
        worker_rank = 0; worker_total = 1; contiguous_mode = 1; first_fastest = 1;
        errors = 0;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
        case (addr)
            bctim_pkg::REG_FIRST_START:  first_start = data[15:0];
            bctim_pkg::REG_FIRST_END:    first_end = data[15:0];
            bctim_pkg::REG_SECOND_START: second_start = data[15:0];
            bctim_pkg::REG_SECOND_END:   second_end = data[15:0];
            bctim_pkg::REG_WORKER_RANK:  worker_rank = data[11:0];
            bctim_pkg::REG_WORKER_TOTAL: worker_total = data[12:0];
            bctim_pkg::REG_CONTIGUOUS:   contiguous_mode = data[0];
            bctim_pkg::REG_FIRST_FAST:   first_fastest = data[0];
            default: ;
        endcase
    endfunction

    function void note_ordinal(logic [31:0] ordinal);
        longint unsigned d1, d2, tasks, workers, n, e, id, count;
        t_map_result r;
        d1 = (first_end > first_start) ? first_end - first_start : 0;
        d2 = (second_end > second_start) ? second_end - second_start : 0;
        tasks = d1 * d2;
        workers = (worker_total != 0) ? worker_total : 1;
        r = '0;
        count = 0;
        if (tasks != 0 && worker_rank < workers) begin
            n = tasks / workers;
            e = tasks % workers;
            count = n + ((worker_rank < e) ? 1 : 0);
            if (ordinal < count) begin
                r.valid_res = 1'b1;
                if (contiguous_mode)
                    id = ordinal + n * worker_rank + ((e < worker_rank) ? e : worker_rank);
                else
                    id = workers * ordinal + worker_rank;
                if (first_fastest) begin
                    r.first_index = 16'(first_start + id % d1);
                    r.second_index = 16'(second_start + id / d1);
                end else begin
                    r.second_index = 16'(second_start + id % d2);
                    r.first_index = 16'(first_start + id / d2);
                end
            end
        end
        r.local_count = 32'(count);
        pending_maps.insert(pending_maps.size(), r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task check_result(logic [71:0] tdata);
        t_map_result want;
        if (pending_maps.size() == 0) begin
            report("unexpected result", tdata[63:0], 0);
            return;
        end
        want = pending_maps.pop_front();
        if (tdata[15:0] !== want.first_index)
            report("first_index", tdata[15:0], want.first_index);
        if (tdata[31:16] !== want.second_index)
            report("second_index", tdata[31:16], want.second_index);
        if (tdata[32] !== want.valid_res)
            report("valid_res", tdata[32], want.valid_res);
        if (tdata[64:33] !== want.local_count)
            report("local_count", tdata[64:33], want.local_count);
    endtask
endclass

module tb_block_cyclic_task_index_map;
    localparam int LATENCY = 17;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;

    index_map_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    block_cyclic_task_index_map DUT (.*);

    always #6 i_clk = ~i_clk;

    // output side: check on transfer, then choose the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high after a transfer so that items can follow back to back
    task send_ordinal(logic [31:0] ordinal);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ordinal;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.note_ordinal(ordinal);
    endtask

    task drain_results();
        s_axis_tvalid <= 1'b0;
        while (board.pending_maps.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task write_reg(logic [2:0] addr, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.write_reg(addr, data);
    endtask

    task set_space(int fs, int fe, int ss, int se, int rank, int total, bit contig, bit ffast);
        drain_results();
        write_reg(bctim_pkg::REG_FIRST_START, fs);
        write_reg(bctim_pkg::REG_FIRST_END, fe);
        write_reg(bctim_pkg::REG_SECOND_START, ss);
        write_reg(bctim_pkg::REG_SECOND_END, se);
        write_reg(bctim_pkg::REG_WORKER_RANK, rank);
        write_reg(bctim_pkg::REG_WORKER_TOTAL, total);
        write_reg(bctim_pkg::REG_CONTIGUOUS, contig);
        write_reg(bctim_pkg::REG_FIRST_FAST, ffast);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly ordinals near the local count, some anywhere
    function automatic logic [31:0] pick_ordinal();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(7);
            default: return $urandom_range(600);
        endcase
    endfunction

    task random_space();
        int fs, ss, total;
        fs = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(40);
        ss = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(40);
        total = $urandom_range(3) == 0 ? $urandom_range(4096) : $urandom_range(1, 9);
        set_space(fs, (fs + $urandom_range(50) - 3) & 16'hffff,
                  ss, (ss + $urandom_range(30) - 2) & 16'hffff,
                  $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(total),
                  total, $urandom_range(1), $urandom_range(1));
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: empty first range
        send_ordinal(0);
        send_ordinal(32'hffffffff);
        // full ranges, one worker: huge count, extreme ordinals
        set_space(0, 65535, 0, 65535, 0, 1, 1, 1);
        send_ordinal(0);
        send_ordinal(32'hfffe0000);
        send_ordinal(32'hffffffff);
        set_space(65535, 65535, 0, 10, 0, 1, 1, 0);
        send_ordinal(0);
        // uneven split, remainder ranks, both modes and orders
        set_space(3, 10, 5, 8, 2, 4, 1, 0);
        send_ordinal(0);
        send_ordinal(5);
        send_ordinal(6);
        set_space(3, 10, 5, 8, 3, 4, 0, 1);
        send_ordinal(0);
        send_ordinal(4);
        send_ordinal(5);
        // zero workers, rank out of range, max rank and total, one-dimensional
        set_space(100, 200, 7, 8, 0, 0, 0, 0);
        send_ordinal(99);
        send_ordinal(100);
        set_space(100, 200, 7, 8, 5, 5, 1, 1);
        send_ordinal(0);
        set_space(0, 65535, 65534, 65535, 4095, 4096, 0, 1);
        send_ordinal(0);
        send_ordinal(15);
        send_ordinal(16);
        set_space(0, 65535, 0, 65535, 4095, 4096, 1, 0);
        send_ordinal(1048575);
        send_ordinal(1048576);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            random_space();
            for (int k = 0; k < 100; k++) begin
                send_ordinal(pick_ordinal());
                if (k == 50) begin
                    s_axis_tvalid <= 1'b0;
                    while (board.pending_maps.size() != 0)
                        @(posedge i_clk);
                end
            end
        end

        recv_stall_pct = 0;
        drain_results();
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
